@@ src/hid_report_descriptor_parser_defines.svh @@
// Assertion macros shared by the HID report descriptor parser modules.
`ifndef HID_REPORT_DESCRIPTOR_PARSER_DEFINES_SVH
`define HID_REPORT_DESCRIPTOR_PARSER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HRDP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HRDP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/hrdp_pkg.sv @@
// Shared constants, item tags, controller states and command/status types.
package hrdp_pkg;

  localparam int DEFAULT_USAGE_SLOTS = 16;
  localparam int DIV_STEPS           = 32;

  localparam logic [7:0] LONG_ITEM_HDR = 8'hFE;
  localparam logic [7:0] TAG_MASK      = 8'hFC;
  localparam logic [7:0] REPORT_ID_BITS = 8'd8;

  localparam logic [7:0] TAG_INPUT        = 8'h80;
  localparam logic [7:0] TAG_OUTPUT       = 8'h90;
  localparam logic [7:0] TAG_COLLECTION   = 8'hA0;
  localparam logic [7:0] TAG_END_COLL     = 8'hC0;
  localparam logic [7:0] TAG_USAGE_PAGE   = 8'h04;
  localparam logic [7:0] TAG_LOGICAL_MIN  = 8'h14;
  localparam logic [7:0] TAG_LOGICAL_MAX  = 8'h24;
  localparam logic [7:0] TAG_REPORT_SIZE  = 8'h74;
  localparam logic [7:0] TAG_REPORT_ID    = 8'h84;
  localparam logic [7:0] TAG_REPORT_COUNT = 8'h94;
  localparam logic [7:0] TAG_USAGE        = 8'h08;
  localparam logic [7:0] TAG_USAGE_MIN    = 8'h18;
  localparam logic [7:0] TAG_USAGE_MAX    = 8'h28;

  localparam logic [1:0] KIND_INPUT   = 2'd0;
  localparam logic [1:0] KIND_OUTPUT  = 2'd1;
  localparam logic [1:0] KIND_SUM_OK  = 2'd2;
  localparam logic [1:0] KIND_SUM_ERR = 2'd3;

  localparam logic [1:0] PH_HDR   = 2'd0;
  localparam logic [1:0] PH_DATA  = 2'd1;
  localparam logic [1:0] PH_LSIZE = 2'd2;
  localparam logic [1:0] PH_LSKIP = 2'd3;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_STEP  = 10'b0000000010,
    S_MAIN  = 10'b0000000100,
    S_DIV   = 10'b0000001000,
    S_RD    = 10'b0000010000,
    S_LOAD  = 10'b0000100000,
    S_WAIT  = 10'b0001000000,
    S_FIN   = 10'b0010000000,
    S_SUM   = 10'b0100000000,
    S_SWAIT = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic ld_range;
    logic div_init;
    logic div_step;
    logic rd;
    logic ld_list;
    logic adv;
    logic fin;
    logic ld_sum;
    logic clr;
  } dp_cmd_t;

  typedef struct packed {
    logic main_go;
    logic eod;
    logic range_mode;
    logic list_nonempty;
    logic div_last;
    logic out_taken;
    logic more;
  } dp_status_t;

endpackage

@@ src/hrdp_ctrl.sv @@
// Controller state machine that sequences byte intake, records and summary.
`include "hid_report_descriptor_parser_defines.svh"

module hrdp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hrdp_pkg::dp_status_t st,
  output hrdp_pkg::dp_cmd_t   cmd
);

  hrdp_pkg::state_t state_r, state_nxt;

  assign in_stall = (state_r != hrdp_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      hrdp_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = hrdp_pkg::S_STEP;
        end
      end
      hrdp_pkg::S_STEP: begin
        cmd.step = 1'b1;
        if (st.main_go) state_nxt = hrdp_pkg::S_MAIN;
        else if (st.eod) state_nxt = hrdp_pkg::S_SUM;
        else state_nxt = hrdp_pkg::S_IDLE;
      end
      hrdp_pkg::S_MAIN: begin
        if (st.range_mode) begin
          cmd.ld_range = 1'b1;
          state_nxt    = hrdp_pkg::S_WAIT;
        end else if (st.list_nonempty) begin
          cmd.div_init = 1'b1;
          state_nxt    = hrdp_pkg::S_DIV;
        end else begin
          state_nxt = hrdp_pkg::S_FIN;
        end
      end
      hrdp_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_nxt = hrdp_pkg::S_RD;
      end
      hrdp_pkg::S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = hrdp_pkg::S_LOAD;
      end
      hrdp_pkg::S_LOAD: begin
        cmd.ld_list = 1'b1;
        state_nxt   = hrdp_pkg::S_WAIT;
      end
      hrdp_pkg::S_WAIT: begin
        if (st.out_taken) begin
          if (st.more) begin
            cmd.adv   = 1'b1;
            state_nxt = hrdp_pkg::S_RD;
          end else begin
            state_nxt = hrdp_pkg::S_FIN;
          end
        end
      end
      hrdp_pkg::S_FIN: begin
        cmd.fin = 1'b1;
        if (st.eod) state_nxt = hrdp_pkg::S_SUM;
        else state_nxt = hrdp_pkg::S_IDLE;
      end
      hrdp_pkg::S_SUM: begin
        cmd.ld_sum = 1'b1;
        state_nxt  = hrdp_pkg::S_SWAIT;
      end
      hrdp_pkg::S_SWAIT: begin
        if (st.out_taken) begin
          cmd.clr   = 1'b1;
          state_nxt = hrdp_pkg::S_IDLE;
        end
      end
      default: state_nxt = hrdp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hrdp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Every accepted word is framed in the following cycle.
  `HRDP_ASSERT_NXT(a_accept_steps, in_valid && !in_stall, state_r == hrdp_pkg::S_STEP, "accepted word not stepped")
  // The divider only runs after a main item has been decoded.
  `HRDP_ASSERT_NXT(a_div_from_main, cmd.div_init, state_r == hrdp_pkg::S_DIV, "divider not started")

endmodule

@@ src/hrdp_datapath.sv @@
// Datapath: item framing, global and local state, usage memory, divider, records.
`include "hid_report_descriptor_parser_defines.svh"

module hrdp_datapath #(
  parameter int USAGE_SLOTS = hrdp_pkg::DEFAULT_USAGE_SLOTS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  hrdp_pkg::dp_cmd_t   cmd,
  output hrdp_pkg::dp_status_t st,
  input  logic [7:0]          in_desc_byte,
  input  logic                in_end_of_descriptor,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_record_kind,
  output logic [15:0]         out_usage_page,
  output logic [7:0]          out_usage_low,
  output logic [7:0]          out_usage_high,
  output logic [15:0]         out_field_size,
  output logic [15:0]         out_field_count,
  output logic [31:0]         out_bit_offset,
  output logic [31:0]         out_bit_length,
  output logic [31:0]         out_main_flags,
  output logic signed [31:0]  out_logical_low,
  output logic signed [31:0]  out_logical_high,
  output logic                out_last
);

  localparam int CW  = $clog2(USAGE_SLOTS + 1);
  localparam int IW  = (USAGE_SLOTS > 1) ? $clog2(USAGE_SLOTS) : 1;
  localparam int ITW = $clog2(hrdp_pkg::DIV_STEPS);

  // Architectural state.
  logic [7:0]    byte_r, byte_nxt;
  logic          eod_r, eod_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [7:0]    hdr_r, hdr_nxt;
  logic [31:0]   accum_r, accum_nxt;
  logic [1:0]    pos_r, pos_nxt;
  logic [2:0]    left_r, left_nxt;
  logic [8:0]    skip_r, skip_nxt;
  logic [7:0]    depth_r, depth_nxt;
  logic [15:0]   page_r, page_nxt;
  logic [31:0]   lmin_r, lmin_nxt;
  logic [31:0]   lmax_r, lmax_nxt;
  logic [15:0]   size_r, size_nxt;
  logic [15:0]   count_r, count_nxt;
  logic          rmin_v_r, rmin_v_nxt;
  logic [7:0]    rmin_r, rmin_nxt;
  logic          rmax_v_r, rmax_v_nxt;
  logic [7:0]    rmax_r, rmax_nxt;
  logic [CW-1:0] ucnt_r, ucnt_nxt;
  logic          e0nz_r, e0nz_nxt;
  logic [15:0]   e0lo_r, e0lo_nxt;
  logic [31:0]   in_bits_r, in_bits_nxt;
  logic [31:0]   out_bits_r, out_bits_nxt;
  logic          rid_r, rid_nxt;
  logic          ignore_r, ignore_nxt;
  logic          gen_set_r, gen_set_nxt;
  logic [15:0]   gen_lo_r, gen_lo_nxt;
  logic          err_r, err_nxt;
  logic          list_r, list_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [ITW-1:0] iter_r, iter_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Working registers of a main item.
  logic [31:0]   prod_r, prod_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [31:0]   flags_r, flags_nxt;
  logic [CW-1:0] rem_len_r, rem_len_nxt;
  logic [CW-1:0] rem_cnt_r, rem_cnt_nxt;
  logic [31:0]   q_len_r, q_len_nxt;
  logic [31:0]   q_cnt_r, q_cnt_nxt;
  logic [31:0]   off_r, off_nxt;
  logic [7:0]    rdata_r;

  // Output word.
  logic [1:0]    o_kind_r, o_kind_nxt;
  logic [15:0]   o_page_r, o_page_nxt;
  logic [7:0]    o_ulo_r, o_ulo_nxt;
  logic [7:0]    o_uhi_r, o_uhi_nxt;
  logic [15:0]   o_size_r, o_size_nxt;
  logic [15:0]   o_cnt_r, o_cnt_nxt;
  logic [31:0]   o_off_r, o_off_nxt;
  logic [31:0]   o_len_r, o_len_nxt;
  logic [31:0]   o_flags_r, o_flags_nxt;
  logic [31:0]   o_lmin_r, o_lmin_nxt;
  logic [31:0]   o_lmax_r, o_lmax_nxt;
  logic          o_last_r, o_last_nxt;

  logic [7:0]    usage_mem [USAGE_SLOTS];
  logic          mem_we;
  logic [7:0]    mem_wd;

  // Framing results for the word in byte_r.
  logic          f_complete, f_chk;
  logic [7:0]    f_hdr, f_tag;
  logic [31:0]   f_val, f_accum;
  logic [1:0]    f_phase, f_pos;
  logic [2:0]    f_left;
  logic [8:0]    f_skip;
  logic [7:0]    f_hdr_keep;

  logic [31:0]   bits_sel;
  logic          more_raw, out_taken, bad;
  logic [CW:0]   sh_len, sh_cnt, dv;
  logic          ge_len, ge_cnt;

  always_comb begin
    f_complete = 1'b0;
    f_chk      = 1'b0;
    f_hdr      = byte_r;
    f_val      = '0;
    f_accum    = accum_r;
    f_phase    = phase_r;
    f_pos      = pos_r;
    f_left     = left_r;
    f_skip     = skip_r;
    f_hdr_keep = hdr_r;
    case (phase_r)
      hrdp_pkg::PH_HDR: begin
        if (byte_r == hrdp_pkg::LONG_ITEM_HDR) begin
          f_phase = hrdp_pkg::PH_LSIZE;
        end else begin
          f_hdr_keep = byte_r;
          f_accum    = '0;
          f_pos      = '0;
          f_left     = (byte_r[1:0] == 2'd3) ? 3'd4 : {1'b0, byte_r[1:0]};
          if (byte_r[1:0] == 2'd0) f_complete = 1'b1;
          else f_phase = hrdp_pkg::PH_DATA;
        end
      end
      hrdp_pkg::PH_DATA: begin
        f_accum = accum_r | ({24'b0, byte_r} << {pos_r, 3'b000});
        f_pos   = pos_r + 2'd1;
        f_left  = left_r - 3'd1;
        f_hdr   = hdr_r;
        f_val   = f_accum;
        if (left_r == 3'd1) begin
          f_phase    = hrdp_pkg::PH_HDR;
          f_complete = 1'b1;
        end
      end
      hrdp_pkg::PH_LSIZE: begin
        f_skip  = {1'b0, byte_r} + 9'd1;
        f_phase = hrdp_pkg::PH_LSKIP;
      end
      default: begin
        f_skip = skip_r - 9'd1;
        if (skip_r == 9'd1) begin
          f_phase = hrdp_pkg::PH_HDR;
          f_chk   = 1'b1;
        end
      end
    endcase
    if (f_complete) f_chk = 1'b1;
    f_tag = f_hdr & hrdp_pkg::TAG_MASK;
  end

  assign bits_sel  = (kind_r == hrdp_pkg::KIND_INPUT) ? in_bits_r : out_bits_r;
  assign more_raw  = ((CW'(idx_r) + CW'(1)) != ucnt_r);
  assign out_taken = out_valid_r && !out_stall;
  assign bad       = (depth_r != '0) || err_r || (phase_r != hrdp_pkg::PH_HDR);

  // One restoring-division step on both quotients; they share the divisor.
  assign dv     = {1'b0, ucnt_r};
  assign sh_len = {rem_len_r, q_len_r[31]};
  assign sh_cnt = {rem_cnt_r, q_cnt_r[31]};
  assign ge_len = (sh_len >= dv);
  assign ge_cnt = (sh_cnt >= dv);

  assign st.main_go = f_complete && !ignore_r &&
                      (f_tag == hrdp_pkg::TAG_INPUT || f_tag == hrdp_pkg::TAG_OUTPUT);
  assign st.eod           = eod_r;
  assign st.range_mode    = rmin_v_r && rmax_v_r;
  assign st.list_nonempty = (ucnt_r != '0);
  assign st.div_last      = (iter_r == ITW'(hrdp_pkg::DIV_STEPS - 1));
  assign st.out_taken     = out_taken;
  assign st.more          = list_r && more_raw;

  always_comb begin
    byte_nxt = byte_r;   eod_nxt = eod_r;     phase_nxt = phase_r; hdr_nxt = hdr_r;
    accum_nxt = accum_r; pos_nxt = pos_r;     left_nxt = left_r;   skip_nxt = skip_r;
    depth_nxt = depth_r; page_nxt = page_r;   lmin_nxt = lmin_r;   lmax_nxt = lmax_r;
    size_nxt = size_r;   count_nxt = count_r;
    rmin_v_nxt = rmin_v_r; rmin_nxt = rmin_r; rmax_v_nxt = rmax_v_r; rmax_nxt = rmax_r;
    ucnt_nxt = ucnt_r;   e0nz_nxt = e0nz_r;   e0lo_nxt = e0lo_r;
    in_bits_nxt = in_bits_r; out_bits_nxt = out_bits_r;
    rid_nxt = rid_r;     ignore_nxt = ignore_r; gen_set_nxt = gen_set_r; gen_lo_nxt = gen_lo_r;
    err_nxt = err_r;     list_nxt = list_r;   idx_nxt = idx_r;     iter_nxt = iter_r;
    prod_nxt = prod_r;   kind_nxt = kind_r;   flags_nxt = flags_r;
    rem_len_nxt = rem_len_r; rem_cnt_nxt = rem_cnt_r;
    q_len_nxt = q_len_r; q_cnt_nxt = q_cnt_r; off_nxt = off_r;
    o_kind_nxt = o_kind_r; o_page_nxt = o_page_r; o_ulo_nxt = o_ulo_r; o_uhi_nxt = o_uhi_r;
    o_size_nxt = o_size_r; o_cnt_nxt = o_cnt_r;   o_off_nxt = o_off_r; o_len_nxt = o_len_r;
    o_flags_nxt = o_flags_r; o_lmin_nxt = o_lmin_r; o_lmax_nxt = o_lmax_r;
    o_last_nxt = o_last_r;
    out_valid_nxt = out_valid_r;
    mem_we = 1'b0;
    mem_wd = f_val[7:0];

    if (out_taken) out_valid_nxt = 1'b0;

    if (cmd.load) begin
      byte_nxt = in_desc_byte;
      eod_nxt  = in_end_of_descriptor;
    end

    if (cmd.step) begin
      phase_nxt = f_phase;
      hdr_nxt   = f_hdr_keep;
      accum_nxt = f_accum;
      pos_nxt   = f_pos;
      left_nxt  = f_left;
      skip_nxt  = f_skip;
      prod_nxt  = size_r * count_r;
      if (f_complete && !ignore_r) begin
        case (f_tag)
          hrdp_pkg::TAG_INPUT: begin
            kind_nxt  = hrdp_pkg::KIND_INPUT;
            flags_nxt = f_val;
          end
          hrdp_pkg::TAG_OUTPUT: begin
            kind_nxt  = hrdp_pkg::KIND_OUTPUT;
            flags_nxt = f_val;
          end
          hrdp_pkg::TAG_COLLECTION: begin
            depth_nxt = depth_r + 8'd1;
            ucnt_nxt  = '0;
          end
          hrdp_pkg::TAG_END_COLL:     depth_nxt = depth_r - 8'd1;
          hrdp_pkg::TAG_USAGE_PAGE:   page_nxt  = f_val[15:0];
          hrdp_pkg::TAG_LOGICAL_MIN:  lmin_nxt  = f_val;
          hrdp_pkg::TAG_LOGICAL_MAX:  lmax_nxt  = f_val;
          hrdp_pkg::TAG_REPORT_SIZE:  size_nxt  = f_val[15:0];
          hrdp_pkg::TAG_REPORT_COUNT: count_nxt = f_val[15:0];
          hrdp_pkg::TAG_REPORT_ID: begin
            if (!rid_r) begin
              rid_nxt     = 1'b1;
              in_bits_nxt = in_bits_r + {24'b0, hrdp_pkg::REPORT_ID_BITS};
            end else begin
              depth_nxt  = '0;
              ignore_nxt = 1'b1;
            end
          end
          hrdp_pkg::TAG_USAGE: begin
            if (ucnt_r < CW'(USAGE_SLOTS)) begin
              mem_we   = 1'b1;
              ucnt_nxt = ucnt_r + CW'(1);
              // Entry zero is mirrored in flops for the generic usage check.
              if (ucnt_r == '0) begin
                e0nz_nxt = (f_val != '0);
                e0lo_nxt = f_val[15:0];
              end
            end else begin
              err_nxt = 1'b1;
            end
          end
          hrdp_pkg::TAG_USAGE_MIN: begin
            rmin_nxt   = f_val[7:0];
            rmin_v_nxt = 1'b1;
          end
          hrdp_pkg::TAG_USAGE_MAX: begin
            rmax_nxt   = f_val[7:0];
            rmax_v_nxt = 1'b1;
          end
          default: ;
        endcase
      end
      if (f_chk && !gen_set_r && depth_nxt == '0 && e0nz_nxt) begin
        gen_set_nxt = 1'b1;
        gen_lo_nxt  = e0lo_nxt;
      end
    end

    if (cmd.ld_range) begin
      o_kind_nxt    = kind_r;    o_page_nxt = page_r;
      o_ulo_nxt     = rmin_r;    o_uhi_nxt  = rmax_r;
      o_size_nxt    = size_r;    o_cnt_nxt  = count_r;
      o_off_nxt     = bits_sel;  o_len_nxt  = prod_r;
      o_flags_nxt   = flags_r;   o_lmin_nxt = lmin_r;  o_lmax_nxt = lmax_r;
      o_last_nxt    = !eod_r;
      out_valid_nxt = 1'b1;
      rmin_v_nxt    = 1'b0;
      rmax_v_nxt    = 1'b0;
      list_nxt      = 1'b0;
    end

    if (cmd.div_init) begin
      rem_len_nxt = '0;
      rem_cnt_nxt = '0;
      q_len_nxt   = prod_r;
      q_cnt_nxt   = {16'b0, count_r};
      iter_nxt    = '0;
      idx_nxt     = '0;
      off_nxt     = bits_sel;
      list_nxt    = 1'b1;
    end

    if (cmd.div_step) begin
      rem_len_nxt = ge_len ? CW'(sh_len - dv) : sh_len[CW-1:0];
      rem_cnt_nxt = ge_cnt ? CW'(sh_cnt - dv) : sh_cnt[CW-1:0];
      q_len_nxt   = {q_len_r[30:0], ge_len};
      q_cnt_nxt   = {q_cnt_r[30:0], ge_cnt};
      iter_nxt    = iter_r + ITW'(1);
    end

    if (cmd.ld_list) begin
      o_kind_nxt    = kind_r;    o_page_nxt = page_r;
      o_ulo_nxt     = rdata_r;   o_uhi_nxt  = rdata_r;
      o_size_nxt    = size_r;    o_cnt_nxt  = q_cnt_r[15:0];
      o_off_nxt     = off_r;     o_len_nxt  = q_len_r;
      o_flags_nxt   = flags_r;   o_lmin_nxt = lmin_r;  o_lmax_nxt = lmax_r;
      o_last_nxt    = !eod_r && !more_raw;
      out_valid_nxt = 1'b1;
    end

    if (cmd.adv) begin
      idx_nxt = idx_r + IW'(1);
      off_nxt = off_r + q_len_r;
    end

    if (cmd.fin) begin
      ucnt_nxt = '0;
      if (kind_r == hrdp_pkg::KIND_INPUT) in_bits_nxt = in_bits_r + prod_r;
      else out_bits_nxt = out_bits_r + prod_r;
    end

    if (cmd.ld_sum) begin
      o_kind_nxt    = bad ? hrdp_pkg::KIND_SUM_ERR : hrdp_pkg::KIND_SUM_OK;
      o_page_nxt    = gen_lo_r;
      o_ulo_nxt     = '0;  o_uhi_nxt = '0;
      o_size_nxt    = '0;  o_cnt_nxt = '0;
      o_off_nxt     = in_bits_r;
      o_len_nxt     = out_bits_r;
      o_flags_nxt   = '0;  o_lmin_nxt = '0;  o_lmax_nxt = '0;
      o_last_nxt    = 1'b1;
      out_valid_nxt = 1'b1;
    end

    // The final word of a descriptor returns the parser to its reset state.
    if (cmd.clr) begin
      phase_nxt = hrdp_pkg::PH_HDR; hdr_nxt = '0; accum_nxt = '0; pos_nxt = '0;
      left_nxt = '0;  skip_nxt = '0;  depth_nxt = '0; page_nxt = '0;
      lmin_nxt = '0;  lmax_nxt = '0;  size_nxt = '0;  count_nxt = '0;
      rmin_v_nxt = 1'b0; rmin_nxt = '0; rmax_v_nxt = 1'b0; rmax_nxt = '0;
      ucnt_nxt = '0;  e0nz_nxt = 1'b0; e0lo_nxt = '0;
      in_bits_nxt = '0; out_bits_nxt = '0; rid_nxt = 1'b0; ignore_nxt = 1'b0;
      gen_set_nxt = 1'b0; gen_lo_nxt = '0; err_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;  eod_r <= 1'b0;  phase_r <= hrdp_pkg::PH_HDR;  hdr_r <= '0;
      accum_r <= '0; pos_r <= '0;    left_r <= '0;    skip_r <= '0;
      depth_r <= '0; page_r <= '0;   lmin_r <= '0;    lmax_r <= '0;
      size_r <= '0;  count_r <= '0;
      rmin_v_r <= 1'b0; rmin_r <= '0; rmax_v_r <= 1'b0; rmax_r <= '0;
      ucnt_r <= '0;  e0nz_r <= 1'b0; e0lo_r <= '0;
      in_bits_r <= '0; out_bits_r <= '0; rid_r <= 1'b0; ignore_r <= 1'b0;
      gen_set_r <= 1'b0; gen_lo_r <= '0; err_r <= 1'b0;
      list_r <= 1'b0; idx_r <= '0;   iter_r <= '0;    out_valid_r <= 1'b0;
      kind_r <= hrdp_pkg::KIND_INPUT;
    end else begin
      byte_r <= byte_nxt;   eod_r <= eod_nxt;     phase_r <= phase_nxt; hdr_r <= hdr_nxt;
      accum_r <= accum_nxt; pos_r <= pos_nxt;     left_r <= left_nxt;   skip_r <= skip_nxt;
      depth_r <= depth_nxt; page_r <= page_nxt;   lmin_r <= lmin_nxt;   lmax_r <= lmax_nxt;
      size_r <= size_nxt;   count_r <= count_nxt;
      rmin_v_r <= rmin_v_nxt; rmin_r <= rmin_nxt; rmax_v_r <= rmax_v_nxt; rmax_r <= rmax_nxt;
      ucnt_r <= ucnt_nxt;   e0nz_r <= e0nz_nxt;   e0lo_r <= e0lo_nxt;
      in_bits_r <= in_bits_nxt; out_bits_r <= out_bits_nxt;
      rid_r <= rid_nxt;     ignore_r <= ignore_nxt;
      gen_set_r <= gen_set_nxt; gen_lo_r <= gen_lo_nxt; err_r <= err_nxt;
      list_r <= list_nxt;   idx_r <= idx_nxt;     iter_r <= iter_nxt;
      out_valid_r <= out_valid_nxt;
      kind_r <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;   flags_r <= flags_nxt;
    rem_len_r <= rem_len_nxt; rem_cnt_r <= rem_cnt_nxt;
    q_len_r <= q_len_nxt; q_cnt_r <= q_cnt_nxt; off_r <= off_nxt;
    o_kind_r <= o_kind_nxt; o_page_r <= o_page_nxt; o_ulo_r <= o_ulo_nxt;
    o_uhi_r <= o_uhi_nxt; o_size_r <= o_size_nxt; o_cnt_r <= o_cnt_nxt;
    o_off_r <= o_off_nxt; o_len_r <= o_len_nxt;   o_flags_r <= o_flags_nxt;
    o_lmin_r <= o_lmin_nxt; o_lmax_r <= o_lmax_nxt; o_last_r <= o_last_nxt;
  end

  // Usage list memory: only entries written since the list was last cleared are read.
  always_ff @(posedge clk) begin
    if (mem_we) usage_mem[ucnt_r[IW-1:0]] <= mem_wd;
    if (cmd.rd) rdata_r <= usage_mem[idx_r];
  end

  assign out_valid        = out_valid_r;
  assign out_record_kind  = o_kind_r;
  assign out_usage_page   = o_page_r;
  assign out_usage_low    = o_ulo_r;
  assign out_usage_high   = o_uhi_r;
  assign out_field_size   = o_size_r;
  assign out_field_count  = o_cnt_r;
  assign out_bit_offset   = o_off_r;
  assign out_bit_length   = o_len_r;
  assign out_main_flags   = o_flags_r;
  assign out_logical_low  = $signed(o_lmin_r);
  assign out_logical_high = $signed(o_lmax_r);
  assign out_last         = o_last_r;

  `HRDP_ASSERT_IMP(a_ucnt_bound, 1'b1, ucnt_r <= CW'(USAGE_SLOTS), "usage count above table size")
  `HRDP_ASSERT_IMP(a_div_nonzero, cmd.div_step, ucnt_r != '0, "division by empty usage list")
  `HRDP_ASSERT_IMP(a_sum_last, out_valid_r && o_kind_r[1], o_last_r, "summary word without last")

endmodule

@@ src/hid_report_descriptor_parser.sv @@
// Top level of the HID report descriptor parser.
// Takes one descriptor byte per accepted word and emits field records for each
// Input or Output main item that has a usage range or list and is not ignored,
// plus a summary record on the byte marked as the end of the descriptor. An
// ordinary byte is accepted, then decoded and executed. A main item with a usage
// range then decides, hands over the record and closes the item, plus any output
// stall. A main item with a usage list decides, runs the shared restoring divider
// at one quotient bit per cycle, then for each record reads the usage memory,
// loads the record and waits for it to be taken, and finally closes the item. A
// main item with no usages decides and closes the item. The summary loads its
// record and waits for it to be taken. Intake stays stalled until all records of
// the current byte are delivered.
module hid_report_descriptor_parser #(
  parameter int USAGE_SLOTS = hrdp_pkg::DEFAULT_USAGE_SLOTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_desc_byte,
  input  logic               in_end_of_descriptor,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_record_kind,
  output logic [15:0]        out_usage_page,
  output logic [7:0]         out_usage_low,
  output logic [7:0]         out_usage_high,
  output logic [15:0]        out_field_size,
  output logic [15:0]        out_field_count,
  output logic [31:0]        out_bit_offset,
  output logic [31:0]        out_bit_length,
  output logic [31:0]        out_main_flags,
  output logic signed [31:0] out_logical_low,
  output logic signed [31:0] out_logical_high,
  output logic               out_last
);

  hrdp_pkg::dp_cmd_t    cmd;
  hrdp_pkg::dp_status_t st;

  hrdp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  hrdp_datapath #(
    .USAGE_SLOTS (USAGE_SLOTS)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .st                   (st),
    .in_desc_byte         (in_desc_byte),
    .in_end_of_descriptor (in_end_of_descriptor),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_record_kind      (out_record_kind),
    .out_usage_page       (out_usage_page),
    .out_usage_low        (out_usage_low),
    .out_usage_high       (out_usage_high),
    .out_field_size       (out_field_size),
    .out_field_count      (out_field_count),
    .out_bit_offset       (out_bit_offset),
    .out_bit_length       (out_bit_length),
    .out_main_flags       (out_main_flags),
    .out_logical_low      (out_logical_low),
    .out_logical_high     (out_logical_high),
    .out_last             (out_last)
  );

endmodule

@@ verif/hid_report_descriptor_parser_tb.sv @@
// Self-checking testbench for the HID report descriptor parser.
module hid_report_descriptor_parser_tb;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] page;
    logic [7:0]  ulo;
    logic [7:0]  uhi;
    logic [15:0] fsize;
    logic [15:0] fcount;
    logic [31:0] offset;
    logic [31:0] length;
    logic [31:0] flags;
    logic [31:0] lmin;
    logic [31:0] lmax;
    logic        last;
  } field_record_t;

  localparam int SLOTS = hrdp_pkg::DEFAULT_USAGE_SLOTS;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_desc_byte = '0;
  logic in_end_of_descriptor = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_record_kind;
  logic [15:0] out_usage_page;
  logic [7:0] out_usage_low;
  logic [7:0] out_usage_high;
  logic [15:0] out_field_size;
  logic [15:0] out_field_count;
  logic [31:0] out_bit_offset;
  logic [31:0] out_bit_length;
  logic [31:0] out_main_flags;
  logic signed [31:0] out_logical_low;
  logic signed [31:0] out_logical_high;
  logic out_last;

  int error_count = 0;
  int send_idle_pct = 20;
  int recv_idle_pct = 50;
  longint cycle_count = 0;

  hid_report_descriptor_parser dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Mirrors the parser state and queues the records each byte must produce.
  class descriptor_scoreboard;
    logic [1:0]  phase;
    logic [7:0]  header;
    logic [31:0] accum;
    int          data_left, data_pos, skip_left;
    logic [7:0]  depth;
    logic [15:0] page, rsize, rcount;
    logic [31:0] lmin, lmax;
    bit          rmin_ok, rmax_ok;
    logic [31:0] rmin, rmax;
    logic [31:0] usages[SLOTS];
    int          n_usages;
    logic [31:0] in_bits, out_bits;
    bit          id_seen, ignoring, overflow;
    logic [31:0] generic;
    field_record_t pending[$];
    field_record_t step_recs[$];

    function new();
      clear();
    endfunction

    function void clear();
      phase = hrdp_pkg::PH_HDR; header = '0; accum = '0;
      data_left = 0; data_pos = 0; skip_left = 0;
      depth = '0; page = '0; rsize = '0; rcount = '0; lmin = '0; lmax = '0;
      rmin_ok = 0; rmax_ok = 0; rmin = '0; rmax = '0;
      foreach (usages[i]) usages[i] = '0;
      n_usages = 0; in_bits = '0; out_bits = '0;
      id_seen = 0; ignoring = 0; overflow = 0; generic = '0;
    endfunction

    function void emit(logic [1:0] k, logic [15:0] pg, logic [31:0] lo, logic [31:0] hi,
                       logic [15:0] sz, logic [15:0] cnt, logic [31:0] off,
                       logic [31:0] len, logic [31:0] fl, logic [31:0] mn,
                       logic [31:0] mx);
      field_record_t r;
      r.kind = k; r.page = pg; r.ulo = lo[7:0]; r.uhi = hi[7:0];
      r.fsize = sz; r.fcount = cnt; r.offset = off; r.length = len;
      r.flags = fl; r.lmin = mn; r.lmax = mx; r.last = 1'b0;
      step_recs.push_back(r);
    endfunction

    function void main_item(logic [1:0] k, logic [31:0] fl);
      logic [31:0] total, base, cnt, len;
      total = 32'(rsize) * 32'(rcount);
      base = (k == hrdp_pkg::KIND_INPUT) ? in_bits : out_bits;
      if (rmin_ok && rmax_ok) begin
        emit(k, page, rmin, rmax, rsize, rcount, base, total, fl, lmin, lmax);
        rmin_ok = 0; rmax_ok = 0;
      end else if (n_usages > 0) begin
        cnt = 32'(rcount) / n_usages;
        len = total / n_usages;
        for (int i = 0; i < n_usages; i++)
          emit(k, page, usages[i], usages[i], rsize, cnt[15:0], base + i * len, len,
               fl, lmin, lmax);
      end
      n_usages = 0;
      if (k == hrdp_pkg::KIND_INPUT) in_bits += total;
      else out_bits += total;
    endfunction

    function void execute(logic [31:0] v);
      if (ignoring) return;
      case (header & hrdp_pkg::TAG_MASK)
        hrdp_pkg::TAG_INPUT:        main_item(hrdp_pkg::KIND_INPUT, v);
        hrdp_pkg::TAG_OUTPUT:       main_item(hrdp_pkg::KIND_OUTPUT, v);
        hrdp_pkg::TAG_COLLECTION: begin depth++; n_usages = 0; end
        hrdp_pkg::TAG_END_COLL:     depth--;
        hrdp_pkg::TAG_USAGE_PAGE:   page = v[15:0];
        hrdp_pkg::TAG_LOGICAL_MIN:  lmin = v;
        hrdp_pkg::TAG_LOGICAL_MAX:  lmax = v;
        hrdp_pkg::TAG_REPORT_SIZE:  rsize = v[15:0];
        hrdp_pkg::TAG_REPORT_COUNT: rcount = v[15:0];
        hrdp_pkg::TAG_REPORT_ID:
          if (!id_seen) begin
            id_seen = 1; in_bits += 32'(hrdp_pkg::REPORT_ID_BITS);
          end else begin
            depth = '0; ignoring = 1;
          end
        hrdp_pkg::TAG_USAGE:
          if (n_usages < SLOTS) usages[n_usages++] = v;
          else overflow = 1;
        hrdp_pkg::TAG_USAGE_MIN: begin rmin = v; rmin_ok = 1; end
        hrdp_pkg::TAG_USAGE_MAX: begin rmax = v; rmax_ok = 1; end
        default: ;
      endcase
    endfunction

    function void update_generic();
      if (generic == 0 && depth == 0 && usages[0] != 0) generic = usages[0];
    endfunction

    function void note_byte(logic [7:0] b, logic eod);
      step_recs.delete();
      case (phase)
        hrdp_pkg::PH_HDR:
          if (b == hrdp_pkg::LONG_ITEM_HDR) phase = hrdp_pkg::PH_LSIZE;
          else begin
            header = b; accum = '0; data_pos = 0;
            data_left = (b[1:0] == 2'd3) ? 4 : b[1:0];
            if (data_left == 0) begin
              execute('0); update_generic();
            end else phase = hrdp_pkg::PH_DATA;
          end
        hrdp_pkg::PH_DATA: begin
          accum |= 32'(b) << (8 * (data_pos % 4));
          data_pos++; data_left--;
          if (data_left == 0) begin
            phase = hrdp_pkg::PH_HDR; execute(accum); update_generic();
          end
        end
        hrdp_pkg::PH_LSIZE: begin skip_left = b + 1; phase = hrdp_pkg::PH_LSKIP; end
        default: begin
          skip_left--;
          if (skip_left == 0) begin
            phase = hrdp_pkg::PH_HDR; update_generic();
          end
        end
      endcase
      if (eod) begin
        emit((depth != 0 || overflow || phase != hrdp_pkg::PH_HDR) ?
               hrdp_pkg::KIND_SUM_ERR : hrdp_pkg::KIND_SUM_OK,
             generic[15:0], '0, '0, '0, '0, in_bits, out_bits, '0, '0, '0);
        clear();
      end
      if (step_recs.size() > 0) step_recs[$].last = 1'b1;
      foreach (step_recs[i]) pending.push_back(step_recs[i]);
    endfunction

    task check_record(field_record_t got);
      field_record_t want;
      if (pending.size() == 0) begin
        report("record with none expected");
        return;
      end
      want = pending.pop_front();
      if (got.kind != want.kind) report($sformatf("kind %0d want %0d", got.kind, want.kind));
      if (got.page != want.page) report($sformatf("page %h want %h", got.page, want.page));
      if (got.ulo != want.ulo) report($sformatf("usage_low %h want %h", got.ulo, want.ulo));
      if (got.uhi != want.uhi) report($sformatf("usage_high %h want %h", got.uhi, want.uhi));
      if (got.fsize != want.fsize) report($sformatf("size %h want %h", got.fsize, want.fsize));
      if (got.fcount != want.fcount)
        report($sformatf("count %h want %h", got.fcount, want.fcount));
      if (got.offset != want.offset)
        report($sformatf("offset %h want %h", got.offset, want.offset));
      if (got.length != want.length)
        report($sformatf("length %h want %h", got.length, want.length));
      if (got.flags != want.flags) report($sformatf("flags %h want %h", got.flags, want.flags));
      if (got.lmin != want.lmin) report($sformatf("lmin %h want %h", got.lmin, want.lmin));
      if (got.lmax != want.lmax) report($sformatf("lmax %h want %h", got.lmax, want.lmax));
      if (got.last != want.last) report($sformatf("last %b want %b", got.last, want.last));
    endtask
  endclass

  descriptor_scoreboard board = new();

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** hid_report_descriptor_parser: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        board.check_record({out_record_kind, out_usage_page, out_usage_low, out_usage_high,
                            out_field_size, out_field_count, out_bit_offset,
                            out_bit_length, out_main_flags, out_logical_low,
                            out_logical_high, out_last});
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Sends one word, holding valid through stalls; random gaps go before it.
  task automatic send_byte(input logic [7:0] b, input logic eod = 1'b0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_desc_byte <= b;
    in_end_of_descriptor <= eod;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_byte(b, eod);
  endtask

  task automatic send_item(input logic [7:0] tag, input logic [31:0] v, input int sz);
    logic [1:0] code;
    code = (sz == 4) ? 2'd3 : 2'(sz);
    send_byte(tag | 8'(code));
    for (int i = 0; i < sz; i++) send_byte(v[8 * i +: 8]);
  endtask

  function automatic int rand_size();
    return (($urandom_range(3) == 3) ? 4 : $urandom_range(2));
  endfunction

  // A descriptor built from sensible items, with a chance of noise bytes.
  task automatic send_descriptor(input int items);
    logic [7:0] tags[13] = '{hrdp_pkg::TAG_INPUT, hrdp_pkg::TAG_OUTPUT,
      hrdp_pkg::TAG_COLLECTION, hrdp_pkg::TAG_END_COLL, hrdp_pkg::TAG_USAGE_PAGE,
      hrdp_pkg::TAG_LOGICAL_MIN, hrdp_pkg::TAG_LOGICAL_MAX, hrdp_pkg::TAG_REPORT_SIZE,
      hrdp_pkg::TAG_REPORT_COUNT, hrdp_pkg::TAG_REPORT_ID, hrdp_pkg::TAG_USAGE,
      hrdp_pkg::TAG_USAGE_MIN, hrdp_pkg::TAG_USAGE_MAX};
    logic [7:0] tag;
    logic [31:0] v;
    for (int k = 0; k < items; k++) begin
      case ($urandom_range(19))
        0: send_byte(8'($urandom()));
        1: begin
          send_byte(hrdp_pkg::LONG_ITEM_HDR);
          send_byte(8'($urandom_range(3)));
          send_byte(8'($urandom()));
        end
        2, 3, 4, 5: send_item(hrdp_pkg::TAG_USAGE, $urandom(), rand_size());
        6, 7: send_item(($urandom_range(1) == 1) ? hrdp_pkg::TAG_INPUT : hrdp_pkg::TAG_OUTPUT,
                        $urandom(), rand_size());
        8: send_item(hrdp_pkg::TAG_REPORT_SIZE, $urandom_range(32), 1);
        9: send_item(hrdp_pkg::TAG_REPORT_COUNT, $urandom_range(20), 1);
        default: begin
          tag = tags[$urandom_range(12)];
          v = $urandom();
          send_item(tag, v, rand_size());
        end
      endcase
    end
    send_byte(8'($urandom()), 1'b1);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: range field, list with uneven split, extremes, overflow.
    send_item(hrdp_pkg::TAG_USAGE_PAGE, 32'hFFFF, 2);
    send_item(hrdp_pkg::TAG_LOGICAL_MIN, 32'h8000_0000, 4);
    send_item(hrdp_pkg::TAG_LOGICAL_MAX, 32'h7FFF_FFFF, 4);
    send_item(hrdp_pkg::TAG_REPORT_SIZE, 32'hFFFF, 2);
    send_item(hrdp_pkg::TAG_REPORT_COUNT, 32'd7, 1);
    send_item(hrdp_pkg::TAG_USAGE_MIN, 32'h01, 1);
    send_item(hrdp_pkg::TAG_USAGE_MAX, 32'hFF, 1);
    send_item(hrdp_pkg::TAG_INPUT, 32'hFFFF_FFFF, 4);
    send_item(hrdp_pkg::TAG_REPORT_ID, 32'd1, 1);
    send_item(hrdp_pkg::TAG_USAGE, 32'h30, 1);
    send_item(hrdp_pkg::TAG_USAGE, 32'h31, 1);
    send_item(hrdp_pkg::TAG_OUTPUT, '0, 0);
    send_byte(8'h00, 1'b1);
    for (int i = 0; i <= SLOTS; i++) send_item(hrdp_pkg::TAG_USAGE, i + 1, 1);
    send_item(hrdp_pkg::TAG_INPUT, 32'h02, 1);
    send_byte(hrdp_pkg::LONG_ITEM_HDR);
    send_byte(8'd2);
    send_byte(8'h00);
    send_byte(8'h00, 1'b1);
    send_item(hrdp_pkg::TAG_REPORT_ID, 32'd1, 1);
    send_item(hrdp_pkg::TAG_REPORT_ID, 32'd2, 1);
    send_item(hrdp_pkg::TAG_COLLECTION, '0, 1);
    send_byte(8'h26, 1'b1);

    for (int p = 0; p < 3; p++) begin
      if (p == 1) begin send_idle_pct = 50; recv_idle_pct = 20; end
      if (p == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int d = 0; d < 4; d++) send_descriptor($urandom_range(3, 8));
    end
    in_valid <= 1'b0;

    while (board.pending.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0 && board.pending.size() == 0)
      $display("** hid_report_descriptor_parser: PASSED **");
    else
      $display("** hid_report_descriptor_parser: FAILED **");
    $finish;
  end
endmodule
